FILE: hdl/assert_macros.svh
// Assertion macros shared by the decompressor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication under the block clock and reset.
`define LZD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under the block clock and reset.
`define LZD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LZD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LZD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/lzd_pkg.sv
// Types and constants shared by the LZ77 token decompressor.
`default_nettype none

package lzd_pkg;

  // History window geometry.
  localparam int HIST_AW    = 16;
  localparam int HIST_DEPTH = 1 << HIST_AW;

  // Decoded bytes packed into one result.
  localparam int PACK_N = 4;

  // Token flag bytes.
  localparam logic [7:0] FLAG_LITERAL = 8'h00;
  localparam logic [7:0] FLAG_MATCH   = 8'h01;

  // Status codes.
  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_TRUNC_LIT   = 3'd1;
  localparam logic [2:0] STS_TRUNC_MATCH = 3'd2;
  localparam logic [2:0] STS_BAD_OFFSET  = 3'd3;
  localparam logic [2:0] STS_BAD_FLAG    = 3'd4;

  // One compressed input byte.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_last;
  } lzd_in_t;

  // One packed result.
  typedef struct packed {
    logic [7:0] out_byte_a;
    logic [7:0] out_byte_b;
    logic [7:0] out_byte_c;
    logic [7:0] out_byte_d;
    logic [2:0] byte_count;
    logic       run_last;
    logic       chunk_done;
    logic [2:0] status;
  } lzd_out_t;

  // Load request from the sequencer to the output register.
  typedef struct packed {
    logic     load;
    lzd_out_t data;
  } lzd_load_t;

endpackage

`default_nettype wire

FILE: hdl/lzd_history_ram.sv
// History window memory: one write port and one registered read port.
`default_nettype none

module lzd_history_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [lzd_pkg::HIST_AW-1:0] wr_addr,
  input  logic [7:0]                 wr_data,
  input  logic                       rd_en,
  input  logic [lzd_pkg::HIST_AW-1:0] rd_addr,
  output logic [7:0]                 rd_data
);
  import lzd_pkg::*;

  logic [7:0] mem [HIST_DEPTH];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hdl/lzd_out_reg.sv
// Output register that holds one result until the consumer takes it.
`default_nettype none

module lzd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  lzd_pkg::lzd_load_t  ld,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output lzd_pkg::lzd_out_t   out_data
);
  import lzd_pkg::*;

  logic     valid_r;
  lzd_out_t data_r;

  // The slot can take a new result when empty or draining this cycle.
  assign free = !valid_r || !out_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld.load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (ld.load) begin
      data_r <= ld.data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

FILE: hdl/lz77_token_decompressor.sv
// LZ77 token decompressor top level: token parser and match copy sequencer.
//
//   Channel | Direction | Payload   | Handshake
//   in_     | input     | lzd_in_t  | in_valid / in_stall
//   out_    | output    | lzd_out_t | out_valid / out_stall
//
// A match copies through the history memory one byte at a time (registered
// read, then write-back), and each result of up to four bytes is then
// handed to the output register.
// The input stalls while a copy runs and while the output register is full.
// Reset (synchronous, rst_n low) clears the parser, pointers and error latch;
// the history memory is not cleared since offsets never reach unwritten bytes.
`default_nettype none
`include "assert_macros.svh"

module lz77_token_decompressor (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lzd_pkg::lzd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lzd_pkg::lzd_out_t out_data
);
  import lzd_pkg::*;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  // Token parse phases.
  localparam logic [2:0] PH_FLAG  = 3'd0;
  localparam logic [2:0] PH_LIT   = 3'd1;
  localparam logic [2:0] PH_OFFHI = 3'd2;
  localparam logic [2:0] PH_OFFLO = 3'd3;
  localparam logic [2:0] PH_LEN   = 3'd4;

  logic [1:0]         state_r, state_nxt;
  logic [2:0]         phase_r, phase_nxt;
  logic [HIST_AW-1:0] wp_r, wp_nxt;
  logic [15:0]        cbc_r, cbc_nxt;
  logic [15:0]        off_r, off_nxt;
  logic               err_r, err_nxt;
  logic [2:0]         err_code_r, err_code_nxt;
  logic [7:0]         rem_r, rem_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic               last_r, last_nxt;
  logic [7:0]         buf_r [PACK_N];
  logic [7:0]         buf_nxt [PACK_N];

  logic               slot_free;
  logic               in_acc;
  lzd_load_t          ld;

  logic               ram_we;
  logic [7:0]         ram_wd;
  logic               ram_re;
  logic [HIST_AW-1:0] ram_ra;
  logic [7:0]         ram_rd;

  logic [15:0]        cbc_inc;
  logic               bad_off;
  logic               grp_end;

  // Input is taken only by the idle parser with room in the output slot.
  assign in_stall = !((state_r == S_IDLE) && slot_free);
  assign in_acc   = in_valid && !in_stall;

  // Read address unit: copy source is the write pointer minus the offset.
  assign ram_ra = wp_r - off_r[HIST_AW-1:0];

  // Saturating chunk byte counter increment.
  assign cbc_inc = (cbc_r == 16'hFFFF) ? cbc_r : cbc_r + 16'd1;

  // Offset must be nonzero, within this chunk and within the window.
  assign bad_off = (off_r == 16'd0) || (off_r > cbc_r) ||
                   ({1'b0, off_r} > 17'(HIST_DEPTH));

  // A result group closes on four bytes or on the final byte of the copy.
  assign grp_end = (cnt_r == 3'(PACK_N - 1)) || (rem_r == 8'd1);

  // Parser and copy sequencer.
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    wp_nxt       = wp_r;
    cbc_nxt      = cbc_r;
    off_nxt      = off_r;
    err_nxt      = err_r;
    err_code_nxt = err_code_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    last_nxt     = last_r;
    buf_nxt      = buf_r;
    ram_we       = 1'b0;
    ram_wd       = in_data.in_byte;
    ram_re       = 1'b0;
    ld           = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ld.data.run_last   = 1'b1;
          ld.data.chunk_done = in_data.chunk_last;
          if (err_r) begin
            // Latched error: echo the code for every byte.
            ld.load        = 1'b1;
            ld.data.status = err_code_r;
          end else begin
            case (phase_r)
              PH_LIT: begin
                ram_we                = 1'b1;
                wp_nxt                = wp_r + 1'b1;
                cbc_nxt               = in_data.chunk_last ? 16'd0 : cbc_inc;
                phase_nxt             = PH_FLAG;
                ld.load               = 1'b1;
                ld.data.out_byte_a    = in_data.in_byte;
                ld.data.byte_count    = 3'd1;
                ld.data.status        = STS_OK;
              end
              PH_OFFHI: begin
                off_nxt = {in_data.in_byte, 8'h00};
                if (in_data.chunk_last) begin
                  err_nxt        = 1'b1;
                  err_code_nxt   = STS_TRUNC_MATCH;
                  ld.load        = 1'b1;
                  ld.data.status = STS_TRUNC_MATCH;
                end else begin
                  phase_nxt = PH_OFFLO;
                end
              end
              PH_OFFLO: begin
                off_nxt = {off_r[15:8], in_data.in_byte};
                if (in_data.chunk_last) begin
                  err_nxt        = 1'b1;
                  err_code_nxt   = STS_TRUNC_MATCH;
                  ld.load        = 1'b1;
                  ld.data.status = STS_TRUNC_MATCH;
                end else begin
                  phase_nxt = PH_LEN;
                end
              end
              PH_LEN: begin
                if (bad_off) begin
                  err_nxt        = 1'b1;
                  err_code_nxt   = STS_BAD_OFFSET;
                  ld.load        = 1'b1;
                  ld.data.status = STS_BAD_OFFSET;
                end else begin
                  phase_nxt = PH_FLAG;
                  if (in_data.in_byte == 8'd0) begin
                    // Empty match only reports when it closes the chunk.
                    if (in_data.chunk_last) begin
                      ld.load        = 1'b1;
                      ld.data.status = STS_OK;
                      cbc_nxt        = 16'd0;
                    end
                  end else begin
                    rem_nxt   = in_data.in_byte;
                    cnt_nxt   = 3'd0;
                    last_nxt  = in_data.chunk_last;
                    buf_nxt   = '{default: 8'h00};
                    state_nxt = S_RD;
                  end
                end
              end
              default: begin
                // Expecting a flag byte.
                phase_nxt = PH_FLAG;
                if (in_data.in_byte == FLAG_LITERAL) begin
                  if (in_data.chunk_last) begin
                    err_nxt        = 1'b1;
                    err_code_nxt   = STS_TRUNC_LIT;
                    ld.load        = 1'b1;
                    ld.data.status = STS_TRUNC_LIT;
                  end else begin
                    phase_nxt = PH_LIT;
                  end
                end else if (in_data.in_byte == FLAG_MATCH) begin
                  if (in_data.chunk_last) begin
                    err_nxt        = 1'b1;
                    err_code_nxt   = STS_TRUNC_MATCH;
                    ld.load        = 1'b1;
                    ld.data.status = STS_TRUNC_MATCH;
                  end else begin
                    phase_nxt = PH_OFFHI;
                  end
                end else begin
                  err_nxt        = 1'b1;
                  err_code_nxt   = STS_BAD_FLAG;
                  ld.load        = 1'b1;
                  ld.data.status = STS_BAD_FLAG;
                end
              end
            endcase
          end
        end
      end

      S_RD: begin
        // Fetch the source byte of this copy step.
        ram_re    = 1'b1;
        state_nxt = S_WR;
      end

      S_WR: begin
        // Append the fetched byte to history and to the result group.
        ram_we         = 1'b1;
        ram_wd         = ram_rd;
        wp_nxt         = wp_r + 1'b1;
        cbc_nxt        = cbc_inc;
        buf_nxt[cnt_r[1:0]] = ram_rd;
        cnt_nxt        = cnt_r + 3'd1;
        rem_nxt        = rem_r - 8'd1;
        state_nxt      = grp_end ? S_EMIT : S_RD;
      end

      S_EMIT: begin
        // Hand the group to the output register once the slot is free.
        if (slot_free) begin
          ld.load            = 1'b1;
          ld.data.out_byte_a = buf_r[0];
          ld.data.out_byte_b = buf_r[1];
          ld.data.out_byte_c = buf_r[2];
          ld.data.out_byte_d = buf_r[3];
          ld.data.byte_count = cnt_r;
          ld.data.run_last   = (rem_r == 8'd0);
          ld.data.chunk_done = (rem_r == 8'd0) && last_r;
          ld.data.status     = STS_OK;
          cnt_nxt            = 3'd0;
          buf_nxt            = '{default: 8'h00};
          if (rem_r == 8'd0) begin
            state_nxt = S_IDLE;
            if (last_r) begin
              cbc_nxt = 16'd0;
            end
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      phase_r    <= PH_FLAG;
      wp_r       <= '0;
      cbc_r      <= '0;
      off_r      <= '0;
      err_r      <= 1'b0;
      err_code_r <= STS_OK;
      rem_r      <= '0;
      cnt_r      <= '0;
      last_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      wp_r       <= wp_nxt;
      cbc_r      <= cbc_nxt;
      off_r      <= off_nxt;
      err_r      <= err_nxt;
      err_code_r <= err_code_nxt;
      rem_r      <= rem_nxt;
      cnt_r      <= cnt_nxt;
      last_r     <= last_nxt;
    end
  end

  // Result group bytes.
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  lzd_history_ram u_hist (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wp_r),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  lzd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .free      (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A fetch is always followed by its write-back.
  `LZD_ASSERT_NXT(a_rd_then_wr, clk, rst_n, state_r == S_RD, state_r == S_WR, "copy fetch not followed by write")
  // An error, once latched, holds until reset.
  `LZD_ASSERT_NXT(a_err_sticky, clk, rst_n, err_r, err_r, "error latch dropped")
  // A group waiting for output is never empty.
  `LZD_ASSERT_IMP(a_emit_nonempty, clk, rst_n, state_r == S_EMIT, cnt_r != 3'd0, "empty group emitted")
  // A fetch only happens with bytes left to copy.
  `LZD_ASSERT_IMP(a_rd_has_work, clk, rst_n, state_r == S_RD, rem_r != 8'd0, "fetch with no bytes left")

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the LZ77 token decompressor: directed and random stream, packed-byte scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import lzd_pkg::*;

  // Parser position inside a token, as the scoreboard tracks it.
  typedef enum logic [2:0] {
    PH_FLAG,
    PH_LITERAL,
    PH_OFF_HI,
    PH_OFF_LO,
    PH_LENGTH
  } parse_phase_t;

  // Kinds of broken token that close the stimulus.
  typedef enum int {
    ERR_TRUNC_LIT,
    ERR_TRUNC_FLAG,
    ERR_TRUNC_HI,
    ERR_TRUNC_LO,
    ERR_ZERO_OFF,
    ERR_FAR_OFF,
    ERR_BAD_FLAG
  } broken_kind_t;

  // One compressed byte waiting to be sent; drain_first holds it until all results are in.
  typedef struct {
    lzd_in_t data;
    bit      drain_first;
  } stream_byte_t;

  localparam int RANDOM_BYTES  = 230;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 1000;
  localparam int PRINT_LIMIT   = 100;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  lzd_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lzd_out_t out_data;

  // Stimulus side.
  stream_byte_t stream_q[$];
  int unsigned  gen_cnt        = 0;
  bit           drain_next     = 1'b0;
  int unsigned  in_gap_left    = 0;
  int unsigned  in_calm_left   = 0;
  bit           stream_drained = 1'b0;

  // Result side.
  int unsigned out_hold_left = 0;
  int unsigned out_calm_left = 0;

  // Scoreboard: decoder state and the decoded results still to come.
  logic [7:0]   hist_mem [0:HIST_DEPTH-1];
  logic [15:0]  hist_wr;
  int unsigned  chunk_bytes;
  parse_phase_t phase;
  logic [15:0]  match_off;
  bit           err_seen;
  logic [2:0]   err_code;
  lzd_out_t     decoded_q[$];
  int           results_due    = 0;
  int unsigned  results_seen   = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles   = 0;

  lz77_token_decompressor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length between transactions: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                results_seen, name, got, want));
    end
  endtask

  // Stimulus building blocks; gen_cnt follows the bytes decoded in the current chunk.
  task automatic push_byte(input logic [7:0] b, input bit last);
    stream_byte_t sb;
    sb.data.in_byte    = b;
    sb.data.chunk_last = last;
    sb.drain_first     = drain_next;
    drain_next         = 1'b0;
    stream_q.insert(stream_q.size(), sb);
  endtask

  task automatic add_literal(input logic [7:0] v, input bit last);
    push_byte(FLAG_LITERAL, 1'b0);
    push_byte(v, last);
    gen_cnt = last ? 0 : gen_cnt + 1;
  endtask

  task automatic add_match(input logic [15:0] off, input logic [7:0] len, input bit last);
    push_byte(FLAG_MATCH, 1'b0);
    push_byte(off[15:8], 1'b0);
    push_byte(off[7:0], 1'b0);
    push_byte(len, last);
    gen_cnt = last ? 0 : gen_cnt + len;
  endtask

  // Well-formed token with random content; offsets always stay inside the chunk.
  task automatic add_random_token();
    int unsigned r;
    int unsigned lim;
    int unsigned off;
    int unsigned len;
    bit          last;
    last = ($urandom_range(0, 11) == 0);
    r    = $urandom_range(0, 99);
    if (gen_cnt == 0 || r < 45) begin
      add_literal(8'($urandom_range(0, 255)), last);
    end else begin
      lim = (gen_cnt > 65535) ? 65535 : gen_cnt;
      case ($urandom_range(0, 3))
        0:       off = 1;
        1:       off = lim;
        default: off = $urandom_range(1, lim);
      endcase
      r = $urandom_range(0, 99);
      if (r < 5) len = 0;
      else if (r < 75) len = $urandom_range(1, 8);
      else if (r < 95) len = $urandom_range(9, 40);
      else if (r < 98) len = $urandom_range(41, 254);
      else len = 255;
      add_match(off[15:0], len[7:0], last);
    end
    if ($urandom_range(0, 39) == 0) drain_next = 1'b1;
  endtask

  // One broken token of a random kind; the error then stays latched for the bytes after it.
  task automatic add_broken_tail();
    broken_kind_t kind;
    int unsigned  off;
    int           i;
    kind = broken_kind_t'($urandom_range(0, 6));
    case (kind)
      ERR_TRUNC_LIT: begin
        push_byte(FLAG_LITERAL, 1'b1);
      end
      ERR_TRUNC_FLAG: begin
        push_byte(FLAG_MATCH, 1'b1);
      end
      ERR_TRUNC_HI: begin
        push_byte(FLAG_MATCH, 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      ERR_TRUNC_LO: begin
        push_byte(FLAG_MATCH, 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      ERR_ZERO_OFF: begin
        push_byte(FLAG_MATCH, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      ERR_FAR_OFF: begin
        off = $urandom_range(65535, gen_cnt + 1);
        push_byte(FLAG_MATCH, 1'b0);
        push_byte(off[15:8], 1'b0);
        push_byte(off[7:0], 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      default: begin
        push_byte(8'($urandom_range(2, 255)), 1'($urandom_range(0, 1)));
      end
    endcase
    for (i = 0; i < 6; i++) begin
      push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Scoreboard helpers.
  task automatic queue_result(input logic [31:0] bytes, input int cnt, input bit run_last,
                              input bit chunk_done, input logic [2:0] code);
    lzd_out_t r;
    r.out_byte_a = bytes[31:24];
    r.out_byte_b = bytes[23:16];
    r.out_byte_c = bytes[15:8];
    r.out_byte_d = bytes[7:0];
    r.byte_count = cnt[2:0];
    r.run_last   = run_last;
    r.chunk_done = chunk_done;
    r.status     = code;
    decoded_q.insert(decoded_q.size(), r);
  endtask

  task automatic store_history(input logic [7:0] v);
    hist_mem[hist_wr] = v;
    hist_wr           = hist_wr + 16'd1;
    if (chunk_bytes < 65535) chunk_bytes++;
  endtask

  task automatic latch_error(input logic [2:0] code, input bit last);
    err_seen = 1'b1;
    err_code = code;
    queue_result(32'h0, 0, 1'b1, last, code);
  endtask

  // Decode one accepted compressed byte and queue the results it produces.
  task automatic decode_byte(input lzd_in_t item);
    logic [7:0]  b;
    bit          last;
    logic [15:0] src;
    logic [7:0]  v;
    logic [31:0] acc;
    int          cnt;
    int          done;
    b    = item.in_byte;
    last = item.chunk_last;
    if (err_seen) begin
      queue_result(32'h0, 0, 1'b1, last, err_code);
    end else begin
      case (phase)
        PH_LITERAL: begin
          store_history(b);
          queue_result({b, 24'h0}, 1, 1'b1, last, STS_OK);
          phase = PH_FLAG;
          if (last) chunk_bytes = 0;
        end
        PH_OFF_HI: begin
          match_off = {b, 8'h00};
          if (last) latch_error(STS_TRUNC_MATCH, 1'b1);
          else phase = PH_OFF_LO;
        end
        PH_OFF_LO: begin
          match_off[7:0] = b;
          if (last) latch_error(STS_TRUNC_MATCH, 1'b1);
          else phase = PH_LENGTH;
        end
        PH_LENGTH: begin
          if (match_off == 16'd0 || match_off > chunk_bytes) begin
            latch_error(STS_BAD_OFFSET, last);
          end else begin
            phase = PH_FLAG;
            if (b == 8'd0) begin
              // A zero-length match only speaks when it closes the chunk.
              if (last) begin
                queue_result(32'h0, 0, 1'b1, 1'b1, STS_OK);
                chunk_bytes = 0;
              end
            end else begin
              // Copy byte by byte so that overlapping copies repeat fresh bytes.
              acc = 32'h0;
              cnt = 0;
              for (done = 0; done < b; done++) begin
                src = hist_wr - match_off;
                v   = hist_mem[src];
                store_history(v);
                acc[31 - 8*cnt -: 8] = v;
                cnt++;
                if (cnt == PACK_N || done + 1 == b) begin
                  queue_result(acc, cnt, done + 1 == b, (done + 1 == b) && last, STS_OK);
                  acc = 32'h0;
                  cnt = 0;
                end
              end
              if (last) chunk_bytes = 0;
            end
          end
        end
        default: begin
          phase = PH_FLAG;
          if (b == FLAG_LITERAL) begin
            if (last) latch_error(STS_TRUNC_LIT, 1'b1);
            else phase = PH_LITERAL;
          end else if (b == FLAG_MATCH) begin
            if (last) latch_error(STS_TRUNC_MATCH, 1'b1);
            else phase = PH_OFF_HI;
          end else begin
            latch_error(STS_BAD_FLAG, last);
          end
        end
      endcase
    end
  endtask

  // Input driver: sends queued bytes with random gaps, holds drain-marked bytes back.
  always @(posedge clk) begin
    stream_byte_t nxt;
    bit           launch;
    bit           valid_next;
    launch     = 1'b0;
    valid_next = in_valid;
    if (rst_n && (!in_valid || !in_stall)) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
      end else if (stream_q.size() > 0 &&
                   (!stream_q[0].drain_first || (!in_valid && results_due == 0))) begin
        launch = 1'b1;
      end
      if (launch) begin
        nxt = stream_q.pop_front();
        in_data <= nxt.data;
        if (in_calm_left > 0) begin
          in_calm_left--;
          in_gap_left = 0;
        end else begin
          in_gap_left = idle_len();
          if ($urandom_range(0, 49) == 0) in_calm_left = $urandom_range(20, 60);
        end
      end
      valid_next = launch;
      in_valid <= launch;
    end
    stream_drained <= (stream_q.size() == 0) && !valid_next;
  end

  // Result side back-pressure: random stalls with calm stretches.
  always @(posedge clk) begin
    if (out_hold_left > 0) begin
      out_hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_calm_left > 0) begin
        out_calm_left--;
      end else begin
        if ($urandom_range(0, 3) == 0) out_hold_left = idle_len();
        if ($urandom_range(0, 199) == 0) out_calm_left = $urandom_range(20, 80);
      end
    end
  end

  // Monitor: predict on each input transaction, then check each result transaction.
  always @(posedge clk) begin
    lzd_out_t want;
    if (!rst_n) begin
      hist_wr     = 16'd0;
      chunk_bytes = 0;
      phase       = PH_FLAG;
      match_off   = 16'd0;
      err_seen    = 1'b0;
      err_code    = STS_OK;
      decoded_q.delete();
      results_due <= 0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_data);
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte_a", out_data.out_byte_a, want.out_byte_a);
          check_field("out_byte_b", out_data.out_byte_b, want.out_byte_b);
          check_field("out_byte_c", out_data.out_byte_c, want.out_byte_c);
          check_field("out_byte_d", out_data.out_byte_d, want.out_byte_d);
          check_field("byte_count", 8'(out_data.byte_count), 8'(want.byte_count));
          check_field("run_last", 8'(out_data.run_last), 8'(want.run_last));
          check_field("chunk_done", 8'(out_data.chunk_done), 8'(want.chunk_done));
          check_field("status", 8'(out_data.status), 8'(want.status));
        end
        results_seen++;
      end
      results_due <= decoded_q.size();
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int start_size;

    // Literal extremes, an overlapping copy, a silent zero-length match, chunk end on a literal.
    add_literal(8'h00, 1'b0);
    add_literal(8'hFF, 1'b0);
    add_match(16'd2, 8'd7, 1'b0);
    add_match(16'd1, 8'd0, 1'b0);
    add_literal(8'h3C, 1'b1);
    // Longest match, then an offset with a nonzero high byte equal to the whole chunk.
    drain_next = 1'b1;
    add_literal(8'h5A, 1'b0);
    add_match(16'd1, 8'd255, 1'b0);
    add_match(16'(gen_cnt), 8'd4, 1'b1);
    // A zero-length match that closes its chunk.
    add_literal(8'h77, 1'b0);
    add_match(16'd1, 8'd0, 1'b1);

    start_size = stream_q.size();
    while (stream_q.size() - start_size < RANDOM_BYTES) add_random_token();
    drain_next = 1'b1;
    add_broken_tail();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (!(stream_drained && results_due == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (results_due != 0) begin
      report_mismatch($sformatf("%0d decoded results never arrived", results_due));
    end
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
